/* src/rdc_pkg.sv */
package rdc_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int MAX_DIGITS_DEF  = 32;

	localparam int RADIX_W = 17;
	localparam int DIGIT_W = 16;
	localparam int POS_W   = 5;
	localparam int COUNT_W = 6;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 17'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 17'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 17'h10000;

	// Controller to datapath
	typedef struct packed {
		logic load;   // take a new value, restart the digit run
		logic step;   // one restoring-division bit
		logic store;  // keep the remainder as the next digit
		logic emit;   // read one digit into the output register
	} rdc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_done;  // this step is the last bit of the division
		logic quo_zero;  // quotient is zero: no more digits
		logic pos_zero;  // the digit being emitted is the least significant
		logic out_free;  // output register empty or draining this cycle
	} rdc_status_t;

	// Clamp the base to the range in which every digit fits 16 bits
	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end
		return res;
	endfunction

endpackage

/* src/rdc_cfg_if.sv */
interface rdc_cfg_if import rdc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [RADIX_W-1:0] radix;

	modport source (output valid, output radix, input ready);
	modport sink   (input valid, input radix, output ready);
endinterface

/* src/rdc_in_if.sv */
interface rdc_in_if import rdc_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

/* src/rdc_out_if.sv */
interface rdc_out_if import rdc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DIGIT_W-1:0] digit;
	logic [POS_W-1:0]   position;
	logic [COUNT_W-1:0] digit_count;
	logic               last;

	modport source (output valid, output digit, output position, output digit_count,
		output last, input ready);
	modport sink   (input valid, input digit, input position, input digit_count,
		input last, output ready);
endinterface

/* src/rdc_ctrl.sv */
module rdc_ctrl import rdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  rdc_status_t st,
	output rdc_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIV   = 4'b0010,
		ST_STORE = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (st.div_done) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				state_d   = st.quo_zero ? ST_EMIT : ST_DIV;
			end
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (st.pos_zero) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// the run ends right after the least significant digit leaves
	a_emit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && st.out_free && st.pos_zero) |=> state_q == ST_IDLE)
		else $error("digit run did not end after the last digit");

	// a division that finished always stores its digit next
	a_div_store: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && st.div_done) |=> cmd.store)
		else $error("finished division did not store a digit");

endmodule

/* src/rdc_dp.sv */
module rdc_dp import rdc_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr,
	input  logic [RADIX_W-1:0]            cfg_radix,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  rdc_cmd_t                      cmd,
	output rdc_status_t                   st,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [DIGIT_W-1:0]            digit,
	output logic [POS_W-1:0]              position,
	output logic [COUNT_W-1:0]            digit_count,
	output logic                          last
);

	localparam int BW = $clog2(VALUE_WIDTH);
	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam int PW = $clog2(MAX_DIGITS);

	logic [RADIX_W-1:0]     radix_q;
	logic [RADIX_W-1:0]     rad_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [BW-1:0]          bit_q;
	logic [CW-1:0]          cnt_q;
	logic [PW-1:0]          pos_q;
	logic                   first_q;
	logic [DIGIT_W-1:0]     mem_q [MAX_DIGITS];

	logic                   out_valid_q;
	logic [DIGIT_W-1:0]     out_digit_q;
	logic [POS_W-1:0]       out_pos_q;
	logic [COUNT_W-1:0]     out_count_q;
	logic                   out_last_q;

	logic [RADIX_W-1:0]     trial;
	logic [RADIX_W-1:0]     diff;
	logic                   ge;
	logic [DIGIT_W-1:0]     rem_d;

	// restoring division, one quotient bit per step
	assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign ge    = trial >= rad_q;
	assign diff  = trial - rad_q;
	assign rem_d = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];

	assign st.div_done = bit_q == BW'(VALUE_WIDTH - 1);
	assign st.quo_zero = quo_q == '0;
	assign st.pos_zero = pos_q == '0;
	assign st.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_wr) begin
			radix_q <= cfg_radix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			bit_q       <= '0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
				bit_q <= '0;
			end else if (cmd.step) begin
				bit_q <= bit_q + 1'b1;
			end else if (cmd.store) begin
				bit_q <= '0;
				if (cnt_q < CW'(MAX_DIGITS)) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.store) begin
				first_q <= 1'b1;
			end else if (cmd.emit) begin
				first_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rad_q <= eff_radix(radix_q);
			quo_q <= value[VALUE_WIDTH-1] ? '0 : value;
			rem_q <= '0;
		end else if (cmd.step) begin
			quo_q <= {quo_q[VALUE_WIDTH-2:0], ge};
			rem_q <= rem_d;
		end else if (cmd.store) begin
			rem_q <= '0;
			pos_q <= (cnt_q < CW'(MAX_DIGITS)) ? cnt_q[PW-1:0] : PW'(MAX_DIGITS - 1);
		end else if (cmd.emit) begin
			pos_q <= pos_q - 1'b1;
		end
	end

	// digit store: written least significant first, read back most significant first
	always_ff @(posedge clk) begin
		if (cmd.store && cnt_q < CW'(MAX_DIGITS)) begin
			mem_q[cnt_q[PW-1:0]] <= rem_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_digit_q <= mem_q[pos_q];
			out_pos_q   <= POS_W'(pos_q);
			out_count_q <= first_q ? COUNT_W'(cnt_q) : '0;
			out_last_q  <= pos_q == '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign digit       = out_digit_q;
	assign position    = out_pos_q;
	assign digit_count = out_count_q;
	assign last        = out_last_q;

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> {1'b0, rem_q} < rad_q)
		else $error("partial remainder reached the base");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("waiting result overwritten");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_DIGITS))
		else $error("digit count beyond store depth");

endmodule

/* src/radix_digit_converter.sv */
// Radix digit converter.
// Channels: din carries one signed value; dout returns one transfer per digit,
// most significant digit first, with its position (power of the base), the
// total digit count on the first digit only (zero on the others), and last on
// the least significant digit. cfg writes the base; its ready is always high.
// A base below 2 is used as 2, one above 65536 as 65536. Zero or a negative
// value gives a single digit 0.
// Timing: each digit comes from a bit-serial restoring divider that works out
// the quotient one bit at a time and then stores the remainder as the digit.
// All digits of a value are divided out before the first digit appears; then
// the block emits one digit per cycle while dout is ready.
// din is taken only while idle; the next value is accepted while the last
// digit of the previous one still waits in the output register.
// A stalled dout holds the current digit and pauses the emit sequence.
// Reset: the base returns to 10, the controller goes idle and dout.valid drops.
module radix_digit_converter import rdc_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rdc_cfg_if.sink    cfg,
	rdc_in_if.sink     din,
	rdc_out_if.source  dout
);

	rdc_cmd_t    cmd;
	rdc_status_t st;

	// base register is always writable
	assign cfg.ready = 1'b1;

	rdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.st       (st),
		.cmd      (cmd)
	);

	rdc_dp #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_DIGITS  (MAX_DIGITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr      (cfg.valid),
		.cfg_radix   (cfg.radix),
		.value       (din.value),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (dout.valid),
		.out_ready   (dout.ready),
		.digit       (dout.digit),
		.position    (dout.position),
		.digit_count (dout.digit_count),
		.last        (dout.last)
	);

endmodule
